### rtl/core/cgem_pkg.sv
// Package for the color gradient edge magnitude block.
// Holds widths, register indexes and configuration reset values; no dependencies.
package cgem_pkg;
  localparam int unsigned DefMaxWidth = 2048;
  localparam int unsigned DefChannels = 3;
  localparam int unsigned PixBits     = 8;
  localparam int unsigned ColBits     = 11;
  localparam int unsigned RowBits     = 16;
  localparam int unsigned CfgWBits    = 12;
  localparam int unsigned GradBits    = 11;  // signed Sobel gradient, |g| <= 1020
  localparam int unsigned ProdBits    = 21;  // signed product of two gradients
  localparam int unsigned SumBits     = 23;  // sum over up to four channels
  localparam int unsigned SqBits      = 46;  // d*d + 4*e*e
  localparam int unsigned RootBits    = 23;  // floor sqrt of SqBits value
  localparam int unsigned LamBits     = 24;
  localparam int unsigned MagRoot     = 12;  // floor sqrt of LamBits value

  localparam logic [0:0] RegWidth  = 1'b0;
  localparam logic [0:0] RegHeight = 1'b1;
  localparam logic [CfgWBits-1:0] WidthReset  = 12'd640;
  localparam logic [RowBits-1:0]  HeightReset = 16'd480;

  // Sideband that travels with a result through the pipeline.
  typedef struct packed {
    logic [ColBits-1:0] col;
    logic [RowBits-1:0] row;
    logic               last;
  } pos_t;
endpackage

### rtl/core/cgem_lane.sv
// One color channel lane: Sobel gradients and their three products.
// Depends on cgem_pkg.
module cgem_lane
  import cgem_pkg::*;
(
  input  logic                       clk,
  input  logic                       en,
  input  logic [PixBits-1:0]         a0, a1, a2, b0, b2, c0, c1, c2,
  output logic signed [ProdBits-1:0] uu,
  output logic signed [ProdBits-1:0] vv,
  output logic signed [ProdBits-1:0] uv
);
  logic signed [GradBits-1:0] u, v;
  logic signed [GradBits-1:0] u_q, v_q;

  // Vertical gradient: lower row minus upper row; horizontal: right minus left.
  // Each weighted sum stays below 1024, so the difference fits GradBits signed.
  always_comb begin
    u = GradBits'($signed({1'b0, GradBits'(a2) + GradBits'(b2) + GradBits'(b2) + GradBits'(c2)})
      - $signed({1'b0, GradBits'(a0) + GradBits'(b0) + GradBits'(b0) + GradBits'(c0)}));
    v = GradBits'($signed({1'b0, GradBits'(c0) + GradBits'(c1) + GradBits'(c1) + GradBits'(c2)})
      - $signed({1'b0, GradBits'(a0) + GradBits'(a1) + GradBits'(a1) + GradBits'(a2)}));
  end

  // Register gradients, then products.
  always_ff @(posedge clk) begin
    if (en) begin
      u_q <= u;
      v_q <= v;
    end
    if (en) begin
      uu <= ProdBits'(u_q * u_q);
      vv <= ProdBits'(v_q * v_q);
      uv <= ProdBits'(u_q * v_q);
    end
  end
endmodule

### rtl/core/cgem_isqrt.sv
// Pipelined floor square root, one result bit per stage.
// Depends on cgem_pkg for nothing but shared style; generic in width.
module cgem_isqrt
  import cgem_pkg::*;
#(
  parameter int unsigned InBits = 46,
  parameter int unsigned Extra  = 1
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [InBits-1:0]        din,
  input  logic [Extra-1:0]         xin,
  output logic [(InBits+1)/2-1:0]  root,
  output logic [Extra-1:0]         xout
);
  localparam int unsigned RB = (InBits + 1) / 2;
  localparam int unsigned XB = 2 * RB;

  logic [XB-1:0] rem_q [RB+1];
  logic [RB-1:0] res_q [RB+1];
  logic [Extra-1:0] x_q [RB+1];

  assign rem_q[0] = XB'(din);
  assign res_q[0] = '0;
  assign x_q[0]   = xin;

  // Stage s decides result bit RB-1-s.
  for (genvar s = 0; s < RB; s++) begin : g_stage
    localparam int unsigned B = RB - 1 - s;
    logic [XB+1:0] trial;
    assign trial = ({2'b0, XB'(res_q[s])} << (B + 1)) | ({{XB{1'b0}}, 2'b01} << (2 * B));
    always_ff @(posedge clk) begin
      if (en) begin
        x_q[s+1] <= x_q[s];
        if ({2'b0, rem_q[s]} >= trial) begin
          rem_q[s+1] <= XB'({2'b0, rem_q[s]} - trial);
          res_q[s+1] <= res_q[s] | (RB'(1) << B);
        end else begin
          rem_q[s+1] <= rem_q[s];
          res_q[s+1] <= res_q[s];
        end
      end
    end
  end

  assign root = res_q[RB];
  assign xout = x_q[RB];
endmodule

### rtl/core/color_gradient_edge_magnitude.sv
// Top level: line stores, 3x3 windows, channel lanes, merge and two square roots.
// Depends on cgem_pkg, cgem_lane and cgem_isqrt.
//
//  channel  | direction | tdata / payload
//  s_axis   | in        | red, green, blue
//  m_axis   | out       | magnitude, out_col, out_row; tlast = frame_end
//  cfg      | in        | index 0 width, 1 height
//
// One pixel per cycle while m_axis is not stalled; most of the pipeline lies in
// the two bit-per-stage square root units. The whole pipeline advances only when
// its output register is free or being taken, so a stalled m_axis holds s_axis.
// Synchronous active-high reset sets default sizes and clears counters, valid bits and window; no clearing pass.
module color_gradient_edge_magnitude
  import cgem_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = DefMaxWidth,
  parameter int unsigned CHANNELS  = DefChannels
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red, green, blue
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // magnitude, out_col, out_row, 5 zero bits
  output logic        m_axis_tlast,   // frame_end
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned PW = PixBits * 4;
  localparam int unsigned PB = $bits(pos_t);
  localparam int unsigned DEPTH = 2 + 2 + 2 + RootBits + 1 + MagRoot;

  logic [CfgWBits-1:0] image_width;
  logic [RowBits-1:0]  image_height;
  logic [RowBits-1:0]  col_count, row_count, w_eff, h_eff;
  logic [PW-1:0] store_upper [MAX_WIDTH];
  logic [PW-1:0] store_middle [MAX_WIDTH];
  logic [PW-1:0] cur, top, mid, cur_q;
  logic [PW-1:0] w0, w1, w2, w3, w4, w5;
  logic [DEPTH-1:0] vld;
  pos_t pos_n, pos_q, pos_d0, pos_d1, pos_d2, pos_m, pos_r, pos_o;
  logic adv, acc, acc_q, has_q;
  logic [AW-1:0] addr, addr_q;

  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign acc = s_axis_tvalid && adv;
  assign cfg_ready = 1'b1;
  assign addr = col_count[AW-1:0];

  // Clamp the configured size.
  always_comb begin
    w_eff = RowBits'(image_width);
    if (w_eff < 16'd3) w_eff = 16'd3;
    if (w_eff > RowBits'(MAX_WIDTH)) w_eff = RowBits'(MAX_WIDTH);
    h_eff = (image_height < 16'd3) ? 16'd3 : image_height;
    cur = '0;
    for (int k = 0; k < 3; k++) begin
      if (k < CHANNELS) cur[PixBits*k +: PixBits] = s_axis_tdata[PixBits*k +: PixBits];
    end
  end

  // Configuration and raster position.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= WidthReset;
      image_height <= HeightReset;
      col_count <= '0;
      row_count <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegWidth:  image_width <= cfg_data[CfgWBits-1:0];
        RegHeight: image_height <= cfg_data;
        default: ;
      endcase
      col_count <= '0;
      row_count <= '0;
    end else if (acc) begin
      if (col_count + 16'd1 >= w_eff) begin
        col_count <= '0;
        row_count <= (row_count + 16'd1 >= h_eff) ? '0 : row_count + 16'd1;
      end else begin
        col_count <= col_count + 16'd1;
      end
    end
  end

  // Line stores: registered reads; the upper store takes the registered middle
  // word in the following cycle, long before that column is read again.
  always_ff @(posedge clk) begin
    if (acc) begin
      top <= store_upper[addr];
      mid <= store_middle[addr];
      store_middle[addr] <= cur;
      addr_q <= addr;
    end
    if (acc_q) store_upper[addr_q] <= mid;
  end

  // Stage 1: hold the pixel and its position beside the store read.
  always_ff @(posedge clk) begin
    if (rst) acc_q <= 1'b0;
    else if (adv) acc_q <= acc;
    if (acc) begin
      cur_q <= cur;
      pos_q.col <= ColBits'(col_count - 16'd1);
      pos_q.row <= row_count - 16'd1;
      pos_q.last <= (row_count == h_eff - 16'd1) && (col_count == w_eff - 16'd1);
      has_q <= (row_count >= 16'd2) && (col_count >= 16'd2);
    end
  end

  // Window shift happens when the store data is available.
  always_ff @(posedge clk) begin
    if (rst) begin
      {w0, w1, w2, w3, w4, w5} <= '0;
    end else if (adv && acc_q) begin
      w3 <= w0; w4 <= w1; w5 <= w2;
      w0 <= top; w1 <= mid; w2 <= cur_q;
    end
  end

  // Lanes, fed from the window before its shift.
  logic signed [ProdBits-1:0] uu [CHANNELS];
  logic signed [ProdBits-1:0] vv [CHANNELS];
  logic signed [ProdBits-1:0] uv [CHANNELS];
  for (genvar k = 0; k < CHANNELS; k++) begin : g_lane
    cgem_lane u_lane (
      .clk(clk), .en(adv),
      .a0(w3[PixBits*k +: PixBits]), .a1(w4[PixBits*k +: PixBits]),
      .a2(w5[PixBits*k +: PixBits]), .b0(w0[PixBits*k +: PixBits]),
      .b2(w2[PixBits*k +: PixBits]), .c0(top[PixBits*k +: PixBits]),
      .c1(mid[PixBits*k +: PixBits]), .c2(cur_q[PixBits*k +: PixBits]),
      .uu(uu[k]), .vv(vv[k]), .uv(uv[k])
    );
  end

  // Merge: sum lanes, then form d and e and the square terms.
  logic signed [SumBits-1:0] gxx, gyy, gxy, sxx, syy, sxy;
  logic [SumBits-1:0] dd, ee;
  logic [LamBits-1:0] tr_m;
  logic [SqBits-1:0] dsq, esq, sq_in;
  logic [LamBits-1:0] tr_d, tr_r;
  always_comb begin
    sxx = '0; syy = '0; sxy = '0;
    for (int k = 0; k < CHANNELS; k++) begin
      sxx = sxx + SumBits'(uu[k]);
      syy = syy + SumBits'(vv[k]);
      sxy = sxy + SumBits'(uv[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pos_d0 <= pos_q;
      pos_d1 <= pos_d0;
      pos_d2 <= pos_d1;
      gxx <= sxx; gyy <= syy; gxy <= sxy;
      pos_m <= pos_d2;
      dd <= (gxx >= gyy) ? SumBits'(gxx - gyy) : SumBits'(gyy - gxx);
      ee <= gxy[SumBits-1] ? SumBits'(-gxy) : SumBits'(gxy);
      tr_m <= LamBits'(gxx) + LamBits'(gyy);
      dsq <= SqBits'(dd * dd);
      esq <= SqBits'(ee * ee);
      tr_d <= tr_m;
      pos_n <= pos_m;
      sq_in <= dsq + (esq << 2);
      tr_r <= tr_d;
      pos_r <= pos_n;
    end
  end

  // Valid shift line tracks items with a result.
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[DEPTH-2:0], acc_q && has_q};
  end

  logic [RootBits-1:0] r;
  logic [LamBits+PB-1:0] rx;
  logic [MagRoot-1:0] m;
  logic [PB-1:0] mx;
  logic [LamBits:0] lam_sum;
  logic [LamBits-1:0] lam;
  cgem_isqrt #(.InBits(SqBits), .Extra(LamBits + PB)) u_sq1 (
    .clk(clk), .en(adv), .din(sq_in), .xin({tr_r, pos_r}), .root(r), .xout(rx)
  );
  assign lam_sum = {1'b0, rx[PB +: LamBits]} + (LamBits+1)'(r);
  always_ff @(posedge clk) begin
    if (adv) begin
      lam <= lam_sum[LamBits:1];
      pos_o <= rx[PB-1:0];
    end
  end
  cgem_isqrt #(.InBits(LamBits), .Extra(PB)) u_sq2 (
    .clk(clk), .en(adv), .din(lam), .xin(pos_o), .root(m), .xout(mx)
  );

  // Output register.
  pos_t pos_f;
  assign pos_f = mx;
  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (adv) m_axis_tvalid <= vld[DEPTH-1];
    if (adv) begin
      m_axis_tdata <= {5'b0, pos_f.row, pos_f.col,
                       (m > MagRoot'(255)) ? 8'hFF : m[7:0]};
      m_axis_tlast <= pos_f.last;
    end
  end

  // Checks.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready)) else $error("ready mismatch");
  a_col: assert property (@(posedge clk) disable iff (rst)
    col_count < w_eff) else $error("column out of range");
endmodule
